// File: rtl/art_pkg.sv
// Package for the address region table: item types, cell control group
// and operation codes. No dependencies.

package art_pkg;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam int ADDR_W  = 64;
    localparam int COUNT_W = 5;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_end;
        logic [ADDR_W-1:0] address;
    } art_cmd_t;

    typedef struct packed {
        logic               hit;
        logic               table_full;
        logic [COUNT_W-1:0] region_count;
    } art_rsp_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic capture;   // register compare results for the new item
        logic append;    // first free cell takes the saved range
        logic remove;    // cells at and after the first cover shift down
    } art_cell_ctl_t;

endpackage

// File: rtl/art_cell.sv
// One entry of the region table: stored range, occupied flag, registered
// compare results and the priority chain link. Depends on art_pkg.

module art_cell
    import art_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  art_cell_ctl_t     ctl,
    input  art_cmd_t          cmd,
    input  logic [ADDR_W-1:0] app_start,
    input  logic [ADDR_W-1:0] app_stop,
    input  logic              prev_occ,
    input  logic              found_in,
    input  logic              lookup_in,
    input  logic              next_occ,
    input  logic [ADDR_W-1:0] next_start,
    input  logic [ADDR_W-1:0] next_stop,
    output logic              occ,
    output logic [ADDR_W-1:0] region_start,
    output logic [ADDR_W-1:0] region_stop,
    output logic              found_out,
    output logic              lookup_out
);

    logic              occ_reg;
    logic              occ_next;
    logic              cover_reg;
    logic              inside_reg;
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] stop_reg;
    logic              take_next;
    logic              take_app;

    // Pass the first-cover and lookup flags down the row
    assign found_out  = found_in | cover_reg;
    assign lookup_out = lookup_in | inside_reg;

    // Shift down from the neighbor at and after the removed entry
    assign take_next = ctl.remove & found_out;
    // The first free cell takes an appended range
    assign take_app  = ctl.append & prev_occ & ~occ_reg;

    always_comb
    begin
        occ_next = occ_reg;
        if (take_next)
        begin
            occ_next = next_occ;
        end
        else if (take_app)
        begin
            occ_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= 1'b0;
            cover_reg  <= 1'b0;
            inside_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (ctl.capture)
            begin
                cover_reg  <= occ_reg && (start_reg <= cmd.range_start)
                                      && (stop_reg >= cmd.range_end);
                inside_reg <= occ_reg && (cmd.address >= start_reg)
                                      && (cmd.address <= stop_reg);
            end
        end
    end

    // Hold the stored range
    always_ff @(posedge clk)
    begin
        if (take_next)
        begin
            start_reg <= next_start;
            stop_reg  <= next_stop;
        end
        else if (take_app)
        begin
            start_reg <= app_start;
            stop_reg  <= app_stop;
        end
    end

    assign occ          = occ_reg;
    assign region_start = start_reg;
    assign region_stop  = stop_reg;

endmodule

// File: rtl/address_region_table.sv
// Top level of the address region table: row of cells, sequencer, count
// and result register. Depends on art_pkg and art_cell.

// Each item is handled in an accept step and an execute step: when it is
// accepted, every cell compares its range against the item and registers
// the outcome; in the execute step the first-cover and lookup flags ripple
// down the row of cells, the table shifts or grows, and the result is
// loaded into the output register. cmd_ready is low during the execute
// step, so the block takes no new item until the current one is done, and
// holds the execute step while an earlier result still waits. The
// stored ranges need no clearing after reset; the occupied flags reset.

module address_region_table
    import art_pkg::*;
#(
    parameter int MAX_REGIONS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  art_cmd_t cmd,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output art_rsp_t rsp
);

    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic              state_reg;
    logic              state_next;
    logic [1:0]        kind_reg;
    logic [ADDR_W-1:0] app_start_reg;
    logic [ADDR_W-1:0] app_stop_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    art_rsp_t          rsp_reg;
    art_rsp_t          rsp_next;

    logic              accept;
    logic              advance;
    logic              is_full;
    logic              append_ok;
    logic              remove_ok;
    logic              lookup_ok;
    logic [CNT_W+4:0]  count_wide;
    art_cell_ctl_t     ctl;

    logic [MAX_REGIONS:0] found_chain;
    logic [MAX_REGIONS:0] lookup_chain;
    logic [MAX_REGIONS:0] occ_chain;
    logic [ADDR_W-1:0]    cell_start [MAX_REGIONS+1];
    logic [ADDR_W-1:0]    cell_stop  [MAX_REGIONS+1];

    assign accept  = cmd_valid & cmd_ready;
    assign advance = (state_reg == ST_EXEC) & (~rsp_valid_reg | rsp_ready);
    assign is_full = (count_reg == CNT_W'(MAX_REGIONS));

    assign append_ok = (kind_reg == KIND_APPEND) & ~is_full;
    assign remove_ok = (kind_reg == KIND_REMOVE) & found_chain[MAX_REGIONS];
    assign lookup_ok = (kind_reg == KIND_LOOKUP) & lookup_chain[MAX_REGIONS];

    assign ctl.capture = accept;
    assign ctl.append  = advance & append_ok;
    assign ctl.remove  = advance & (kind_reg == KIND_REMOVE);

    // Chain ends: head sees an occupied neighbor, tail sees an empty one
    assign found_chain[0]          = 1'b0;
    assign lookup_chain[0]         = 1'b0;
    assign occ_chain[MAX_REGIONS]  = 1'b0;
    assign cell_start[MAX_REGIONS] = '0;
    assign cell_stop[MAX_REGIONS]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_REGIONS; gi++)
        begin : g_cell
            logic prev_occ;
            if (gi == 0)
            begin : g_head
                assign prev_occ = 1'b1;
            end
            else
            begin : g_body
                assign prev_occ = occ_chain[gi-1];
            end

            art_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (ctl),
                .cmd          (cmd),
                .app_start    (app_start_reg),
                .app_stop     (app_stop_reg),
                .prev_occ     (prev_occ),
                .found_in     (found_chain[gi]),
                .lookup_in    (lookup_chain[gi]),
                .next_occ     (occ_chain[gi+1]),
                .next_start   (cell_start[gi+1]),
                .next_stop    (cell_stop[gi+1]),
                .occ          (occ_chain[gi]),
                .region_start (cell_start[gi]),
                .region_stop  (cell_stop[gi]),
                .found_out    (found_chain[gi+1]),
                .lookup_out   (lookup_chain[gi+1])
            );
        end
    endgenerate

    // Sequence: accept, then execute once the result register is free
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Track the entry count
    always_comb
    begin
        count_next = count_reg;
        if (advance && append_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (advance && remove_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Build the result item
    assign count_wide = {5'd0, count_next};

    always_comb
    begin
        rsp_next.hit          = append_ok | remove_ok | lookup_ok;
        rsp_next.table_full   = (kind_reg == KIND_APPEND) & is_full;
        rsp_next.region_count = count_wide[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the item fields needed in the execute cycle, and the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= cmd.kind;
            app_start_reg <= cmd.range_start;
            app_stop_reg  <= cmd.range_end;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: rtl/art_checker.sv
// Port-level checks for the address region table, bound to the top level.
// Depends on art_pkg and address_region_table.

module art_checker
    import art_pkg::*;
#(
    parameter int MAX_REGIONS = 16
)
(
    input logic     clk,
    input logic     rst_n,
    input logic     cmd_valid,
    input logic     cmd_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input art_rsp_t rsp
);

    // A stalled result item holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    // A dropped append never reports a hit
    a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.table_full |-> !rsp.hit)
        else $error("dropped append reported a hit");

    // A dropped append only happens with the table at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.table_full |-> rsp.region_count == COUNT_W'(MAX_REGIONS))
        else $error("table flagged full below capacity");

    // One item at a time: no acceptance right after an acceptance
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("second item accepted while one is in work");

endmodule

bind address_region_table art_checker #(.MAX_REGIONS(MAX_REGIONS)) u_art_checker (.*);
